/* hw/rtl/positional_pid_integral_separation_defines.svh */
// Assertion macros shared by the PID datapath modules.
`ifndef POSITIONAL_PID_INTEGRAL_SEPARATION_DEFINES_SVH
`define POSITIONAL_PID_INTEGRAL_SEPARATION_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define PPIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define PPIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPIS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/ppis_pkg.sv */
`default_nettype none

package ppis_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P           = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I           = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D           = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEGRATE_WINDOW = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_LIMIT   = 3'd4;

  localparam logic [15:0] GAIN_P_RST           = 16'd256;
  localparam logic [15:0] GAIN_I_RST           = 16'd0;
  localparam logic [15:0] GAIN_D_RST           = 16'd0;
  localparam logic [15:0] INTEGRATE_WINDOW_RST = 16'd100;
  localparam logic [15:0] INTEGRAL_LIMIT_RST   = 16'd4000;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        integrate_window;
    logic [15:0]        integral_limit;
  } cfg_t;

  // Operands handed from the error stage to the multiply-accumulate stage.
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [17:0] integ;
    logic signed [17:0] deriv;
  } operand_t;

endpackage

`default_nettype wire

/* hw/rtl/positional_pid_integral_separation.sv */
// Positional PID controller with integral separation and integral clamp.
// Each input word carries a measured value and a target; the block forms
// error = measured - target, adds it to the integral only while |error| is
// strictly below integrate_window (clamping to +/- integral_limit), and
// returns drive = (Kp*e + Ki*integral + Kd*(e - previous e)) >> 8 with Q8.8
// gains and floor rounding. One word is accepted every cycle unless a result
// stalls on m_tready. The accepting edge loads the input register; the error
// stage and then the multiply-accumulate stage register the word before its
// result is offered. The rate is set by the integral and previous error
// loop, which closes through the error stage's own registers. Gains and
// thresholds are written through the configuration channel, which is always
// ready, and should be changed only while no word is in flight.
`default_nettype none

module positional_pid_integral_separation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [31:0]                  s_tdata,  // measured [15:0], target [31:16]
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [31:0]                       m_tdata,  // drive [31:0]
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ppis_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                  cfg_data_i
);

  ppis_pkg::cfg_t     cfg;
  ppis_pkg::operand_t op;
  logic               op_valid, op_ready;

  ppis_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppis_error_stage u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .measured_i ($signed(s_tdata[15:0])),
    .target_i   ($signed(s_tdata[31:16])),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  ppis_mac_stage u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .res_valid_o (m_tvalid),
    .res_ready_i (m_tready),
    .drive_o     (m_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/ppis_cfg_regs.sv */
`default_nettype none

module ppis_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ppis_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                 cfg_data_i,
  output ppis_pkg::cfg_t                   cfg_o
);

  ppis_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppis_pkg::REG_GAIN_P:           cfg_d.gain_p           = cfg_data_i;
        ppis_pkg::REG_GAIN_I:           cfg_d.gain_i           = cfg_data_i;
        ppis_pkg::REG_GAIN_D:           cfg_d.gain_d           = cfg_data_i;
        ppis_pkg::REG_INTEGRATE_WINDOW: cfg_d.integrate_window = cfg_data_i;
        ppis_pkg::REG_INTEGRAL_LIMIT:   cfg_d.integral_limit   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p           <= ppis_pkg::GAIN_P_RST;
      cfg_q.gain_i           <= ppis_pkg::GAIN_I_RST;
      cfg_q.gain_d           <= ppis_pkg::GAIN_D_RST;
      cfg_q.integrate_window <= ppis_pkg::INTEGRATE_WINDOW_RST;
      cfg_q.integral_limit   <= ppis_pkg::INTEGRAL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/ppis_error_stage.sv */
`default_nettype none

`include "positional_pid_integral_separation_defines.svh"

module ppis_error_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ppis_pkg::cfg_t    cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic signed [15:0] measured_i,
  input  wire logic signed [15:0] target_i,
  output logic                   op_valid_o,
  input  wire logic              op_ready_i,
  output ppis_pkg::operand_t     op_o
);

  logic               in_valid_q;
  logic signed [15:0] meas_q, targ_q;
  logic               op_valid_q;
  ppis_pkg::operand_t op_q, op_d;
  logic signed [17:0] integral_q, integral_d;
  logic signed [16:0] prev_q;

  logic               op_adv;
  logic               in_ready;
  logic signed [16:0] err;
  logic signed [17:0] err_x, win_x;
  logic               in_window;
  logic signed [18:0] sum, lim;

  function automatic logic signed [16:0] measured_ext(input logic signed [15:0] v);
    measured_ext = 17'(v);
  endfunction

  assign op_adv   = !op_valid_q || op_ready_i;
  assign in_ready = !in_valid_q || op_adv;

  // Error, windowed integration with clamp, and the derivative difference.
  always_comb begin
    err       = 17'(measured_ext(meas_q)) - 17'(measured_ext(targ_q));
    err_x     = 18'(err);
    win_x     = $signed({2'b00, cfg_i.integrate_window});
    in_window = (err_x < win_x) && (err_x > -win_x);
    sum       = 19'(integral_q) + 19'(err);
    lim       = $signed({3'b000, cfg_i.integral_limit});
    integral_d = integral_q;
    if (in_window) begin
      if (sum > lim) begin
        integral_d = lim[17:0];
      end else if (sum < -lim) begin
        integral_d = 18'(-lim);
      end else begin
        integral_d = sum[17:0];
      end
    end
    op_d.err   = err;
    op_d.integ = integral_d;
    op_d.deriv = err_x - 18'(prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      op_valid_q <= 1'b0;
      integral_q <= '0;
      prev_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (op_adv) begin
        op_valid_q <= in_valid_q;
        if (in_valid_q) begin
          integral_q <= integral_d;
          prev_q     <= err;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      meas_q <= measured_i;
      targ_q <= target_i;
    end
    if (op_adv && in_valid_q) begin
      op_q <= op_d;
    end
  end

  assign in_ready_o = in_ready;
  assign op_valid_o = op_valid_q;
  assign op_o       = op_q;

  // The clamp keeps the stored integral within the largest possible limit.
  `PPIS_ASSERT(integ_bound_a, clk_i, rst_ni,
    (integral_q <= 18'sd65535) && (integral_q >= -18'sd65535),
    "stored integral outside the clamp range")
  // The error handed on becomes the previous error for the next word.
  `PPIS_ASSERT(prev_track_a, clk_i, rst_ni,
    op_adv && in_valid_q |=> prev_q == op_q.err,
    "previous error does not follow the issued operand")
  // A stalled operand freezes the controller state.
  `PPIS_ASSERT(stall_hold_a, clk_i, rst_ni,
    op_valid_q && !op_ready_i |=> $stable(integral_q) && $stable(prev_q) && $stable(op_q),
    "controller state moved while the operand was stalled")

endmodule

`default_nettype wire

/* hw/rtl/ppis_mac_stage.sv */
`default_nettype none

`include "positional_pid_integral_separation_defines.svh"

module ppis_mac_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppis_pkg::cfg_t cfg_i,
  input  wire logic          op_valid_i,
  output logic               op_ready_o,
  input  wire ppis_pkg::operand_t op_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic [31:0]        drive_o
);

  logic               res_valid_q;
  logic [31:0]        drive_q, drive_d;
  logic               res_ready;
  logic signed [32:0] prod_p;
  logic signed [33:0] prod_i, prod_d;
  logic signed [35:0] acc;

  assign res_ready = !res_valid_q || res_ready_i;

  assign prod_p = $signed(cfg_i.gain_p) * $signed(op_i.err);
  assign prod_i = $signed(cfg_i.gain_i) * $signed(op_i.integ);
  assign prod_d = $signed(cfg_i.gain_d) * $signed(op_i.deriv);
  assign acc    = 36'(prod_p) + 36'(prod_i) + 36'(prod_d);

  // The sum stays below 2^34 in magnitude, so after the Q8.8 floor shift it
  // always fits the signed 32-bit drive and no saturation is needed.
  assign drive_d = {{4{acc[35]}}, acc[35:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && op_valid_i) begin
      drive_q <= drive_d;
    end
  end

  assign op_ready_o  = res_ready;
  assign res_valid_o = res_valid_q;
  assign drive_o     = drive_q;

  `PPIS_ASSERT(res_hold_a, clk_i, rst_ni,
    res_valid_q && !res_ready_i |=> res_valid_q && $stable(drive_q),
    "pending result changed before it was taken")
  `PPIS_ASSERT(res_load_a, clk_i, rst_ni,
    op_valid_i && res_ready |=> res_valid_q && drive_q == $past(drive_d),
    "operand accepted but result not loaded")
  `PPIS_ASSERT(res_drain_a, clk_i, rst_ni,
    !op_valid_i && res_ready |=> !res_valid_q,
    "result register holds a word that was never issued")

endmodule

`default_nettype wire
